FILE: sv/elpg_pkg.sv
// Shared constants and types for the eased line point generator.
package elpg_pkg;

    localparam int ELPG_COORD_BITS = 12;

    localparam int CFG_DATA_W = 12;
    localparam int STEP_W     = 12;
    localparam int RAMP_W     = 10;
    localparam int SPEED_W    = 8;
    localparam int COLOR_W    = 8;

    localparam logic [STEP_W-1:0]  STEP_SIZE_RST = STEP_W'(20);
    localparam logic [RAMP_W-1:0]  RAMP_LEN_RST  = RAMP_W'(136);
    localparam logic [SPEED_W-1:0] SPEED_MAX     = {SPEED_W{1'b1}};

    // configuration register indexes
    typedef enum logic {
        CFG_STEP_SIZE = 1'b0,
        CFG_RAMP_LEN  = 1'b1
    } t_cfg_idx;

    // compare-subtract unit operation
    typedef enum logic {
        CS_DIV  = 1'b0,
        CS_SQRT = 1'b1
    } t_cs_mode;

    typedef struct packed {
        logic     start;
        t_cs_mode mode;
    } t_cs_ctl;

endpackage

FILE: sv/elpg_cs.sv
// Shared iterative compare-subtract unit: restoring divide or digit-by-digit square root.
module elpg_cs #(
    parameter int COORD_BITS = elpg_pkg::ELPG_COORD_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  elpg_pkg::t_cs_ctl         i_ctl,
    input  logic [2*COORD_BITS+9:0]   i_num,
    input  logic [COORD_BITS+4:0]     i_den,
    output logic                      o_done,
    output logic [COORD_BITS+4:0]     o_res,
    output logic [COORD_BITS+7:0]     o_rem
);
    import elpg_pkg::*;

    localparam int NW = 2*COORD_BITS + 10;
    localparam int SW = COORD_BITS + 5;
    localparam int RW = COORD_BITS + 8;
    localparam int CW = $clog2(NW + 1);
    localparam logic [CW-1:0] SQ_ITERS = CW'(NW / 2);
    localparam logic [CW-1:0] DV_ITERS = CW'(NW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_num;
    logic [RW-1:0] r_rem;
    logic [SW-1:0] r_res;
    logic [SW-1:0] r_den;
    t_cs_mode      r_mode;

    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;
    logic [RW-1:0] diff;
    logic          ge;

    always_comb begin
        if (r_mode == CS_SQRT) begin
            rem_sh = {r_rem[RW-3:0], r_num[NW-1 -: 2]};
            trial  = {{(RW-SW-2){1'b0}}, r_res, 2'b01};
        end else begin
            rem_sh = {r_rem[RW-2:0], r_num[NW-1]};
            trial  = {{(RW-SW){1'b0}}, r_den};
        end
        ge   = (rem_sh >= trial);
        diff = rem_sh - trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_mode <= CS_DIV;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_mode <= i_ctl.mode;
                r_cnt  <= (i_ctl.mode == CS_SQRT) ? SQ_ITERS : DV_ITERS;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_res <= '0;
        end else if (r_busy) begin
            r_num <= (r_mode == CS_SQRT) ? {r_num[NW-3:0], 2'b00} : {r_num[NW-2:0], 1'b0};
            r_rem <= ge ? diff : rem_sh;
            r_res <= {r_res[SW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;
    assign o_rem  = r_rem;

endmodule

FILE: sv/eased_line_point_generator.sv
// Top level of the eased line point generator: item sequencer, segment state and output word.
// Every accepted word gives exactly one output word. A segment word (kind 0) holds the input
// stall for two squares on the shared multiplier, a square root and the step division on the
// shared compare-subtract unit. A tick on a running segment holds it for two interpolation
// divisions of 2*COORD_BITS+10 bits each, one quotient bit per cycle. Rejected segments, idle
// ticks and the tick on a zero-length segment hold it only for the output state. The next word
// is taken in the cycle the stall drops. The output word sits in a register, so a new input
// word may be taken while the previous result waits; a result still waiting when the next one
// is ready stretches the stall.
module eased_line_point_generator #(
    parameter int COORD_BITS = elpg_pkg::ELPG_COORD_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_idx,
    input  logic [elpg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_kind,
    input  logic [COORD_BITS-1:0]           i_target_x,
    input  logic [COORD_BITS-1:0]           i_target_y,
    input  logic [elpg_pkg::COLOR_W-1:0]    i_red_in,
    input  logic [elpg_pkg::COLOR_W-1:0]    i_green_in,
    input  logic [elpg_pkg::COLOR_W-1:0]    i_blue_in,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_point_valid,
    output logic [COORD_BITS-1:0]           o_point_x,
    output logic [COORD_BITS-1:0]           o_point_y,
    output logic [elpg_pkg::COLOR_W-1:0]    o_red_out,
    output logic [elpg_pkg::COLOR_W-1:0]    o_green_out,
    output logic [elpg_pkg::COLOR_W-1:0]    o_blue_out,
    output logic                            o_segment_done,
    output logic                            o_rejected
);
    import elpg_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int NW = 2*C + 10;
    localparam int SW = C + 5;
    localparam int RW = C + 8;
    localparam int PW = SW + 1;
    localparam int MW = SW + C;
    localparam int QW = 2*C + 1;

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_SQX    = 13'b0000000000010,
        ST_SQY    = 13'b0000000000100,
        ST_ROOT   = 13'b0000000001000,
        ST_ROOT_W = 13'b0000000010000,
        ST_DIV    = 13'b0000000100000,
        ST_DIV_W  = 13'b0000001000000,
        ST_RAMP   = 13'b0000010000000,
        ST_LX     = 13'b0000100000000,
        ST_LX_W   = 13'b0001000000000,
        ST_LY     = 13'b0010000000000,
        ST_LY_W   = 13'b0100000000000,
        ST_OUT    = 13'b1000000000000
    } t_state;

    typedef enum logic [1:0] {
        OK_NONE = 2'd0,
        OK_REJ  = 2'd1,
        OK_END  = 2'd2,
        OK_PT   = 2'd3
    } t_okind;

    t_state r_state;
    t_okind r_okind;
    logic   r_lerp_go;

    logic [STEP_W-1:0]  r_step_size;
    logic [RAMP_W-1:0]  r_ramp_len;

    logic               r_busy;
    logic [C-1:0]       r_start_x, r_start_y, r_end_x, r_end_y;
    logic [SW-1:0]      r_steps;
    logic [PW-1:0]      r_cnt;
    logic [SPEED_W-1:0] r_speed;
    logic [COLOR_W-1:0] r_red, r_green, r_blue;

    logic [MW-1:0]      r_prod;
    logic [QW-1:0]      r_acc;
    logic [C-1:0]       r_px, r_py;

    logic               r_ov;
    logic               r_o_valid, r_o_done, r_o_rej;
    logic [C-1:0]       r_o_x, r_o_y;
    logic [COLOR_W-1:0] r_o_red, r_o_green, r_o_blue;

    // axis deltas
    logic [C:0]   dxs, dys;
    logic [C-1:0] adx, ady;
    logic         neg_x, neg_y;

    assign dxs   = {1'b0, r_end_x} - {1'b0, r_start_x};
    assign dys   = {1'b0, r_end_y} - {1'b0, r_start_y};
    assign neg_x = dxs[C];
    assign neg_y = dys[C];
    assign adx   = neg_x ? C'(-dxs) : dxs[C-1:0];
    assign ady   = neg_y ? C'(-dys) : dys[C-1:0];

    // shared multiplier
    logic [SW-1:0] mul_a;
    logic [C-1:0]  mul_b;
    logic [MW-1:0] mul_p;

    always_comb begin
        unique case (r_state)
            ST_SQX:  begin mul_a = SW'(adx);         mul_b = adx; end
            ST_SQY:  begin mul_a = SW'(ady);         mul_b = ady; end
            ST_LY:   begin mul_a = r_cnt[SW-1:0];    mul_b = ady; end
            default: begin mul_a = r_cnt[SW-1:0];    mul_b = adx; end
        endcase
        mul_p = MW'(mul_a) * MW'(mul_b);
    end

    // compare-subtract unit
    t_cs_ctl        cs_ctl;
    logic [NW-1:0]  cs_num;
    logic [SW-1:0]  cs_den;
    logic           cs_done;
    logic [SW-1:0]  cs_res;
    logic [RW-1:0]  cs_rem;
    logic [SW-1:0]  cs_ceil;
    logic [QW-1:0]  sq_sum;
    logic [SW-1:0]  step_div;

    assign sq_sum   = r_acc + r_prod[QW-1:0];
    assign cs_ceil  = cs_res + SW'(cs_rem != '0);
    assign step_div = (r_step_size == '0) ? SW'(1) : SW'(r_step_size);

    always_comb begin
        cs_ctl.start = 1'b0;
        cs_ctl.mode  = CS_DIV;
        cs_num       = NW'(r_prod);
        cs_den       = r_steps;
        unique case (r_state) inside
            ST_ROOT: begin
                cs_ctl.start = 1'b1;
                cs_ctl.mode  = CS_SQRT;
                cs_num       = {1'b0, sq_sum, 8'b0};
            end
            ST_DIV: begin
                cs_ctl.start = 1'b1;
                cs_num       = NW'(cs_ceil);
                cs_den       = step_div;
            end
            ST_LX_W, ST_LY_W: begin
                cs_ctl.start = r_lerp_go;
            end
            default: ;
        endcase
    end

    elpg_cs #(
        .COORD_BITS (COORD_BITS)
    ) u_cs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (cs_ctl),
        .i_num   (cs_num),
        .i_den   (cs_den),
        .o_done  (cs_done),
        .o_res   (cs_res),
        .o_rem   (cs_rem)
    );

    // ramp rules
    logic [SW-1:0]      half;
    logic [PW:0]        cnt_ramp;
    logic               ramp_up, ramp_dn;
    logic [SPEED_W-1:0] spd_up, spd_dn, n_speed;

    always_comb begin
        half     = r_steps >> 1;
        cnt_ramp = {1'b0, r_cnt} + (PW+1)'(r_ramp_len);
        ramp_up  = (r_cnt <= PW'(r_ramp_len)) && (r_cnt < PW'(half)) && (r_speed != SPEED_MAX);
        spd_up   = ramp_up ? r_speed + 1'b1 : r_speed;
        ramp_dn  = (cnt_ramp >= (PW+1)'(r_steps)) && (r_cnt > PW'(half)) && (spd_up != '0);
        spd_dn   = ramp_dn ? spd_up - 1'b1 : spd_up;
        n_speed  = (spd_dn == '0) ? SPEED_W'(1) : spd_dn;
    end

    logic [C-1:0] lerp_q;
    logic [C-1:0] lerp_x, lerp_y;
    logic [PW-1:0] n_cnt;
    logic          accept, out_free;
    logic          n_ov;

    assign lerp_q   = cs_res[C-1:0];
    assign lerp_x   = neg_x ? r_start_x - lerp_q : r_start_x + lerp_q;
    assign lerp_y   = neg_y ? r_start_y - lerp_q : r_start_y + lerp_q;
    assign n_cnt    = r_cnt + PW'(r_speed);
    assign accept   = i_in_valid && (r_state == ST_IDLE);
    assign out_free = !r_ov || !i_out_stall;
    assign n_ov     = (r_state == ST_OUT && out_free) || (r_ov && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_size <= STEP_SIZE_RST;
            r_ramp_len  <= RAMP_LEN_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_STEP_SIZE: r_step_size <= i_cfg_data[STEP_W-1:0];
                CFG_RAMP_LEN:  r_ramp_len  <= i_cfg_data[RAMP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_okind   <= OK_NONE;
            r_lerp_go <= 1'b0;
            r_busy    <= 1'b0;
            r_start_x <= '0;
            r_start_y <= '0;
            r_end_x   <= '0;
            r_end_y   <= '0;
            r_steps   <= '0;
            r_cnt     <= '0;
            r_speed   <= '0;
            r_red     <= '0;
            r_green   <= '0;
            r_blue    <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_lerp_go <= (r_state == ST_LX) || (r_state == ST_LY);
            r_ov      <= n_ov;
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        if (!i_kind) begin
                            if (r_busy) begin
                                r_okind <= OK_REJ;
                                r_state <= ST_OUT;
                            end else begin
                                r_start_x <= r_end_x;
                                r_start_y <= r_end_y;
                                r_end_x   <= i_target_x;
                                r_end_y   <= i_target_y;
                                r_red     <= i_red_in;
                                r_green   <= i_green_in;
                                r_blue    <= i_blue_in;
                                r_cnt     <= '0;
                                r_speed   <= '0;
                                r_busy    <= 1'b1;
                                r_okind   <= OK_NONE;
                                r_state   <= ST_SQX;
                            end
                        end else if (!r_busy) begin
                            r_okind <= OK_NONE;
                            r_state <= ST_OUT;
                        end else if (r_steps == '0) begin
                            r_okind <= OK_END;
                            r_state <= ST_OUT;
                        end else begin
                            r_okind <= OK_PT;
                            r_state <= ST_RAMP;
                        end
                    end
                end
                ST_SQX:  r_state <= ST_SQY;
                ST_SQY:  r_state <= ST_ROOT;
                ST_ROOT: r_state <= ST_ROOT_W;
                ST_ROOT_W: begin
                    if (cs_done) begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: r_state <= ST_DIV_W;
                ST_DIV_W: begin
                    if (cs_done) begin
                        r_steps <= cs_ceil;
                        r_state <= ST_OUT;
                    end
                end
                ST_RAMP: begin
                    r_speed <= n_speed;
                    r_state <= ST_LX;
                end
                ST_LX: begin
                    r_state <= ST_LX_W;
                end
                ST_LX_W: begin
                    if (cs_done) begin
                        r_state <= ST_LY;
                    end
                end
                ST_LY: begin
                    r_state <= ST_LY_W;
                end
                ST_LY_W: begin
                    if (cs_done) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                        if (r_okind == OK_END) begin
                            r_busy <= 1'b0;
                        end else if (r_okind == OK_PT) begin
                            r_cnt <= n_cnt;
                            if (n_cnt > PW'(r_steps)) begin
                                r_busy <= 1'b0;
                            end
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SQX || r_state == ST_SQY || r_state == ST_LX || r_state == ST_LY) begin
            r_prod <= mul_p;
        end
        if (r_state == ST_SQY) begin
            r_acc <= r_prod[QW-1:0];
        end
        if (r_state == ST_LX_W && cs_done) begin
            r_px <= lerp_x;
        end
        if (r_state == ST_LY_W && cs_done) begin
            r_py <= lerp_y;
        end
    end

    // output word
    logic               n_o_valid, n_o_done, n_o_rej;
    logic [C-1:0]       n_o_x, n_o_y;
    logic [COLOR_W-1:0] n_o_red, n_o_green, n_o_blue;

    always_comb begin
        n_o_valid = 1'b0;
        n_o_done  = 1'b0;
        n_o_rej   = 1'b0;
        n_o_x     = '0;
        n_o_y     = '0;
        n_o_red   = '0;
        n_o_green = '0;
        n_o_blue  = '0;
        case (r_okind)
            OK_REJ: n_o_rej = 1'b1;
            OK_END: begin
                n_o_valid = 1'b1;
                n_o_done  = 1'b1;
                n_o_x     = r_end_x;
                n_o_y     = r_end_y;
                n_o_red   = r_red;
                n_o_green = r_green;
                n_o_blue  = r_blue;
            end
            OK_PT: begin
                n_o_valid = 1'b1;
                n_o_done  = (n_cnt > PW'(r_steps));
                n_o_x     = r_px;
                n_o_y     = r_py;
                n_o_red   = r_red;
                n_o_green = r_green;
                n_o_blue  = r_blue;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && out_free) begin
            r_o_valid <= n_o_valid;
            r_o_done  <= n_o_done;
            r_o_rej   <= n_o_rej;
            r_o_x     <= n_o_x;
            r_o_y     <= n_o_y;
            r_o_red   <= n_o_red;
            r_o_green <= n_o_green;
            r_o_blue  <= n_o_blue;
        end
    end

    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = r_ov;
    assign o_point_valid  = r_o_valid;
    assign o_point_x      = r_o_x;
    assign o_point_y      = r_o_y;
    assign o_red_out      = r_o_red;
    assign o_green_out    = r_o_green;
    assign o_blue_out     = r_o_blue;
    assign o_segment_done = r_o_done;
    assign o_rejected     = r_o_rej;

endmodule
